### rtl/bsks_pkg.sv
// ----------------------------------------------------------------------------
// bsks_pkg: shared types and codes for the bounded stack with key search
// Operation and status codes, request/response payloads, cell control.
// ----------------------------------------------------------------------------
package bsks_pkg;

    // default configuration
    localparam int DEPTH_DEF       = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // one request
    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key_value;
        logic [7:0]         tag_char;
    } t_req;

    // one response
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         position;
        logic signed [31:0] out_value;
        logic [7:0]         out_tag;
        logic [3:0]         fill_count;
    } t_rsp;

    // per-cell update controls
    typedef struct packed {
        logic load;   // take the pushed entry
        logic shift;  // take the entry of the cell above
    } t_cell_ctl;

endpackage

### rtl/bsks_cell.sv
// ----------------------------------------------------------------------------
// bsks_cell: one stack slot
// Holds a (value, tag) entry, compares it against the search key when a
// request is taken, and loads either a pushed entry or its upper neighbor.
// ----------------------------------------------------------------------------
module bsks_cell #(
    parameter int VALUE_WIDTH = bsks_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_capture,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  bsks_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_push_value,
    input  logic [7:0]             i_push_tag,
    input  logic [VALUE_WIDTH-1:0] i_above_value,
    input  logic [7:0]             i_above_tag,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [7:0]             o_tag,
    output logic                   o_hit
);

    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [7:0]             r_tag, n_tag;
    logic                   r_hit, n_hit;

    // entry update: push load or shift down from above
    always_comb begin
        n_value = r_value;
        n_tag   = r_tag;
        if (i_ctl.load) begin
            n_value = i_push_value;
            n_tag   = i_push_tag;
        end else if (i_ctl.shift) begin
            n_value = i_above_value;
            n_tag   = i_above_tag;
        end
    end

    // key compare, sampled when the request is taken
    always_comb begin
        n_hit = r_hit;
        if (i_capture) begin
            n_hit = (r_value == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_tag   <= n_tag;
        r_hit   <= n_hit;
    end

    assign o_value = r_value;
    assign o_tag   = r_tag;
    assign o_hit   = r_hit;

endmodule

### rtl/bounded_stack_with_key_search.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_key_search: LIFO stack of (value, tag) with key search
// Flow: each cell registers its key compare when a request is taken; the
//   request is then resolved while pending and its response strobe is registered.
// Busy is high while a request is pending, so a new request is taken only
//   once the pending one is resolved; the receiver cannot stall.
// Reset: the stack pointer clears (stack empty); entries are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_key_search #(
    parameter int DEPTH       = bsks_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bsks_pkg::VALUE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bsks_pkg::t_req i_req,
    output logic           o_valid,
    output bsks_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = (CNT_W > 4) ? CNT_W : 4;

    logic                   accept;
    logic [63:0]            key_ext;
    logic [VALUE_WIDTH-1:0] key_vw;

    logic                   r_pend;
    bsks_pkg::t_req         r_req;
    logic [VALUE_WIDTH-1:0] r_key_vw;
    logic [CNT_W-1:0]       r_sp, n_sp;
    logic                   r_valid;
    bsks_pkg::t_rsp         r_rsp, n_rsp;

    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [7:0]             cell_tag   [DEPTH];
    logic [DEPTH-1:0]       cell_hit;
    logic [DEPTH-1:0]       occ;
    bsks_pkg::t_cell_ctl    cell_ctl   [DEPTH];

    logic                   found;
    logic [IDX_W-1:0]       hit_idx;
    logic [CNT_W-1:0]       sp_m1;
    logic [IDX_W-1:0]       rd_idx;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [63:0]            rd_ext;
    logic                   is_full;
    logic                   do_push;
    logic                   do_remove;
    logic [PW-1:0]          pos_full;
    logic [PW-1:0]          fill_full;

    assign accept = start && !busy;
    assign busy   = r_pend;

    // key trimmed to the stored width
    assign key_ext = {{32{i_req.key_value[31]}}, i_req.key_value};
    assign key_vw  = key_ext[VALUE_WIDTH-1:0];

    // row of cells, bottom entry at index 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] above_value;
        logic [7:0]             above_tag;

        if (i == DEPTH - 1) begin : g_top
            assign above_value = '0;
            assign above_tag   = '0;
        end else begin : g_mid
            assign above_value = cell_value[i+1];
            assign above_tag   = cell_tag[i+1];
        end

        assign occ[i] = (CNT_W'(i) < r_sp);

        assign cell_ctl[i].load  = do_push && (CNT_W'(i) == r_sp);
        assign cell_ctl[i].shift = do_remove && (IDX_W'(i) >= hit_idx)
                                   && (CNT_W'(i + 1) < r_sp);

        bsks_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_capture     (accept),
            .i_key         (key_vw),
            .i_ctl         (cell_ctl[i]),
            .i_push_value  (r_key_vw),
            .i_push_tag    (r_req.tag_char),
            .i_above_value (above_value),
            .i_above_tag   (above_tag),
            .o_value       (cell_value[i]),
            .o_tag         (cell_tag[i]),
            .o_hit         (cell_hit[i])
        );
    end

    // topmost occupied match
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_hit[i] && occ[i]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign is_full   = (r_sp == CNT_W'(DEPTH));
    assign do_push   = r_pend && (r_req.operation == bsks_pkg::OP_PUSH) && !is_full;
    assign do_remove = r_pend && (r_req.operation == bsks_pkg::OP_REMOVE) && found;

    // single read port: top for pop, match for remove
    assign sp_m1    = r_sp - CNT_W'(1);
    assign rd_idx   = (r_req.operation == bsks_pkg::OP_POP) ? sp_m1[IDX_W-1:0] : hit_idx;
    assign rd_value = cell_value[rd_idx];
    assign rd_ext   = {{(64 - VALUE_WIDTH){rd_value[VALUE_WIDTH-1]}}, rd_value};

    assign pos_full = PW'(r_sp) - PW'(hit_idx);

    // resolve the pending request
    always_comb begin
        n_sp  = r_sp;
        n_rsp = '0;
        case (r_req.operation)
            bsks_pkg::OP_PUSH: begin
                if (is_full) begin
                    n_rsp.status = bsks_pkg::ST_FULL;
                end else begin
                    n_sp = r_sp + CNT_W'(1);
                end
            end
            bsks_pkg::OP_POP: begin
                if (r_sp == '0) begin
                    n_rsp.status = bsks_pkg::ST_EMPTY;
                end else begin
                    n_sp            = sp_m1;
                    n_rsp.out_value = rd_ext[31:0];
                    n_rsp.out_tag   = cell_tag[rd_idx];
                end
            end
            bsks_pkg::OP_FIND, bsks_pkg::OP_REMOVE: begin
                if (!found) begin
                    n_rsp.status = bsks_pkg::ST_NOT_FOUND;
                end else begin
                    n_rsp.position = pos_full[3:0];
                    if (r_req.operation == bsks_pkg::OP_REMOVE) begin
                        n_sp            = sp_m1;
                        n_rsp.out_value = rd_ext[31:0];
                        n_rsp.out_tag   = cell_tag[rd_idx];
                    end
                end
            end
            default: begin
                n_sp = r_sp;
            end
        endcase
        fill_full        = PW'(n_sp);
        n_rsp.fill_count = fill_full[3:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend  <= accept;
            r_valid <= r_pend;
            if (r_pend) begin
                r_sp <= n_sp;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req;
            r_key_vw <= key_vw;
        end
        if (r_pend) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    // fill never exceeds the depth
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(DEPTH))
        else $error("stack pointer above depth");

    // a taken request is resolved in the next cycle and answered after it
    a_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("response strobe missing after resolve");

    // a strobe only follows a resolve cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_pend))
        else $error("response strobe without request");

    // full status leaves the stack at its depth
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == bsks_pkg::ST_FULL)) |-> (r_sp == CNT_W'(DEPTH)))
        else $error("full reported while not full");

    // shift and load never hit the same cell
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_push && do_remove))
        else $error("push and remove in the same cycle");
`endif

endmodule
